[design/contiguous_page_frame_allocator_defines.svh]
// Assertion macros for the contiguous page frame allocator.
// Used by modules that include this header; expects clk_i and rst_ni in scope.
`ifndef CONTIGUOUS_PAGE_FRAME_ALLOCATOR_DEFINES_SVH
`define CONTIGUOUS_PAGE_FRAME_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS

// Implication within the same cycle
`define CPFA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication into the next cycle
`define CPFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CPFA_ASSERT_IMPL(lbl, ante, cons, msg)

`define CPFA_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[design/cpfa_pkg.sv]
// Shared types, constants and helpers for the contiguous page frame allocator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cpfa_pkg;

  // Map geometry
  localparam int unsigned MAP_PAGES  = 1024;
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned IDX_W      = $clog2(MAP_PAGES);
  localparam int unsigned ENTRY_W    = $clog2(MAP_PAGES + 1);
  localparam int unsigned CNT_W      = ENTRY_W;

  // Field widths
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned LEN_W      = 11;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [LEN_W-1:0] PAGES_RESET = LEN_W'(1024);

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_NOROOM = 2'd1,
    ST_BAD    = 2'd2
  } status_e;

  typedef enum logic {
    CFG_FRAME_BASE    = 1'b0,
    CFG_PAGES_MANAGED = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_WRITE,
    S_FREE
  } state_e;

  typedef struct packed {
    op_e               operation;
    logic [LEN_W-1:0]  run_length;
    logic [ADDR_W-1:0] free_address;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [ADDR_W-1:0] run_address;
  } rsp_t;

  // One write port and one read port into the page map
  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [ENTRY_W-1:0] wdata;
    logic               re;
    logic [IDX_W-1:0]   raddr;
  } map_req_t;

  // Entries in use, capped at the map depth
  function automatic logic [CNT_W-1:0] pages_in_use(input logic [LEN_W-1:0] pm);
    logic [CNT_W-1:0] lim;
    if (32'(pm) > 32'(MAP_PAGES)) begin
      lim = CNT_W'(MAP_PAGES);
    end else begin
      lim = CNT_W'(pm);
    end
    return lim;
  endfunction

endpackage

`default_nettype wire

[design/contiguous_page_frame_allocator.sv]
// Top level of the contiguous page frame allocator: configuration registers,
// sequencer and page map RAM. Depends on cpfa_pkg, cpfa_map_ram, cpfa_ctrl.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   Request channel: an item (allocate or free) is taken at a clock edge with
//   start high and busy low. busy stays high until the item is finished.
//   Result channel: done_o pulses for exactly one cycle with result_o; the
//   receiver cannot stall it, and busy drops in that same cycle, so the next
//   item may be started while the result is on the port.
//   Config channel: cfg_valid_i with cfg_index_i/cfg_data_i, always ready.
//   Write it only while no item is in flight.
// Sequence of an item:
//   request refused on its fields: answered straight from decode; free of a
//   page that is already free: refused after the first map read.
//   allocate: a first-fit scan reads the map from page 0 up, then the run of
//   n pages is written; a failed scan reads every page in use.
//   free: pages are cleared while their numbering keeps counting up, until
//   the run ends or reaches the last page in use.
//   The page map takes one map read and one map write per cycle.
// Reset: the page map is swept to zero, one entry per cycle over all 1024
//   entries; busy is high meanwhile and configuration writes are still taken.

module contiguous_page_frame_allocator (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire cpfa_pkg::req_t                      req_i,
  output logic                                     done_o,
  output cpfa_pkg::rsp_t                           result_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire cpfa_pkg::cfg_idx_e                  cfg_index_i,
  input  wire logic [cpfa_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  logic [cpfa_pkg::ADDR_W-1:0]  frame_base_q, frame_base_d;
  logic [cpfa_pkg::LEN_W-1:0]   pages_managed_q, pages_managed_d;
  cpfa_pkg::map_req_t           map_req;
  logic [cpfa_pkg::ENTRY_W-1:0] map_rdata;

  assign cfg_ready_o = 1'b1;

  // Configuration register writes
  always_comb begin
    frame_base_d    = frame_base_q;
    pages_managed_d = pages_managed_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        cpfa_pkg::CFG_FRAME_BASE:    frame_base_d    = cfg_data_i[cpfa_pkg::ADDR_W-1:0];
        cpfa_pkg::CFG_PAGES_MANAGED: pages_managed_d = cfg_data_i[cpfa_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_base_q    <= '0;
      pages_managed_q <= cpfa_pkg::PAGES_RESET;
    end else begin
      frame_base_q    <= frame_base_d;
      pages_managed_q <= pages_managed_d;
    end
  end

  // Sequencer
  cpfa_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_o          (busy),
    .req_i           (req_i),
    .done_o          (done_o),
    .result_o        (result_o),
    .frame_base_i    (frame_base_q),
    .pages_managed_i (pages_managed_q),
    .map_req_o       (map_req),
    .map_rdata_i     (map_rdata)
  );

  // Page map storage
  cpfa_map_ram u_map_ram (
    .clk_i   (clk_i),
    .req_i   (map_req),
    .rdata_o (map_rdata)
  );

endmodule

`default_nettype wire

[design/cpfa_map_ram.sv]
// Page map storage: one write port, one registered read port.
// Depends on cpfa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cpfa_map_ram (
  input  wire logic                          clk_i,
  input  wire cpfa_pkg::map_req_t            req_i,
  output logic [cpfa_pkg::ENTRY_W-1:0]       rdata_o
);

  logic [cpfa_pkg::ENTRY_W-1:0] mem_q [cpfa_pkg::MAP_PAGES];
  logic [cpfa_pkg::ENTRY_W-1:0] rdata_q;

  // Synchronous write and registered read
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[design/cpfa_ctrl.sv]
// Sequencer for the page frame allocator: clear pass, first-fit scan,
// run write-back and run free, all through the page map RAM.
// Depends on cpfa_pkg and contiguous_page_frame_allocator_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "contiguous_page_frame_allocator_defines.svh"

module cpfa_ctrl (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  output logic                                     busy_o,
  input  wire cpfa_pkg::req_t                      req_i,
  output logic                                     done_o,
  output cpfa_pkg::rsp_t                           result_o,
  input  wire logic [cpfa_pkg::ADDR_W-1:0]         frame_base_i,
  input  wire logic [cpfa_pkg::LEN_W-1:0]          pages_managed_i,
  output cpfa_pkg::map_req_t                       map_req_o,
  input  wire logic [cpfa_pkg::ENTRY_W-1:0]        map_rdata_i
);

  cpfa_pkg::state_e                  state_q, state_d;
  cpfa_pkg::op_e                     op_q, op_d;
  logic [cpfa_pkg::LEN_W-1:0]        len_q, len_d;
  logic [cpfa_pkg::ADDR_W-1:0]       addr_q, addr_d;
  logic [cpfa_pkg::CNT_W-1:0]        ra_q, ra_d;
  logic                              rd_vld_q, rd_vld_d;
  logic [cpfa_pkg::IDX_W-1:0]        rd_idx_q, rd_idx_d;
  logic [cpfa_pkg::CNT_W-1:0]        cnt_q, cnt_d;
  logic [cpfa_pkg::IDX_W-1:0]        start_q, start_d;
  logic [cpfa_pkg::ENTRY_W-1:0]      prev_q, prev_d;
  logic                              first_q, first_d;
  logic [cpfa_pkg::IDX_W-1:0]        wr_idx_q, wr_idx_d;
  logic [cpfa_pkg::ENTRY_W-1:0]      wr_val_q, wr_val_d;
  logic                              done_q, done_d;
  cpfa_pkg::rsp_t                    rsp_q, rsp_d;

  logic [cpfa_pkg::CNT_W-1:0]        limit;
  logic                              alloc_bad;
  logic [cpfa_pkg::ADDR_W-1:0]       offset;
  logic [cpfa_pkg::ADDR_W-1:0]       page_idx;
  logic                              free_bad;
  logic                              scan_free;
  logic                              scan_hit;
  logic                              scan_last;
  logic                              scan_issue;
  logic                              write_last;
  logic                              clear_last;
  logic [31:0]                       next_k;
  logic                              free_more;
  logic                              free_match;
  logic                              free_cont;

  // Request decode
  assign limit     = cpfa_pkg::pages_in_use(pages_managed_i);
  assign alloc_bad = (len_q == '0) || (32'(len_q) > 32'(limit));
  assign offset    = addr_q - frame_base_i;
  assign page_idx  = offset >> cpfa_pkg::PAGE_SHIFT;
  assign free_bad  = (addr_q < frame_base_i) || (page_idx >= 32'(limit));

  // First-fit scan conditions on the entry returned this cycle
  assign scan_free  = (map_rdata_i == '0);
  assign scan_hit   = rd_vld_q && scan_free && ((32'(cnt_q) + 32'd1) == 32'(len_q));
  assign scan_last  = rd_vld_q && ((32'(rd_idx_q) + 32'd1) == 32'(limit));
  assign scan_issue = !scan_hit && (ra_q < limit);
  assign write_last = (32'(wr_val_q) == 32'(len_q));
  assign clear_last = (wr_idx_q == cpfa_pkg::IDX_W'(cpfa_pkg::MAP_PAGES - 1));

  // Run free: follow the numbering while it keeps counting up
  assign next_k     = 32'(rd_idx_q) + 32'd1;
  assign free_more  = (next_k < 32'(limit));
  assign free_match = ({1'b0, map_rdata_i} ==
                       ((cpfa_pkg::ENTRY_W + 1)'(prev_q) + (cpfa_pkg::ENTRY_W + 1)'(1)));
  assign free_cont  = first_q ? !scan_free : free_match;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cpfa_pkg::S_CLEAR: begin
        if (clear_last) state_d = cpfa_pkg::S_IDLE;
      end
      cpfa_pkg::S_IDLE: begin
        if (start_i) state_d = cpfa_pkg::S_DECODE;
      end
      cpfa_pkg::S_DECODE: begin
        unique case (op_q)
          cpfa_pkg::OP_ALLOC: state_d = alloc_bad ? cpfa_pkg::S_IDLE : cpfa_pkg::S_SCAN;
          cpfa_pkg::OP_FREE:  state_d = free_bad  ? cpfa_pkg::S_IDLE : cpfa_pkg::S_FREE;
          default:            state_d = cpfa_pkg::S_IDLE;
        endcase
      end
      cpfa_pkg::S_SCAN: begin
        priority if (scan_hit) state_d = cpfa_pkg::S_WRITE;
        else if (scan_last)    state_d = cpfa_pkg::S_IDLE;
        else                   state_d = state_q;
      end
      cpfa_pkg::S_WRITE: begin
        if (write_last) state_d = cpfa_pkg::S_IDLE;
      end
      cpfa_pkg::S_FREE: begin
        if (!free_cont || !free_more) state_d = cpfa_pkg::S_IDLE;
      end
      default: state_d = cpfa_pkg::S_IDLE;
    endcase
  end

  // Datapath, map accesses and result
  always_comb begin
    op_d      = op_q;
    len_d     = len_q;
    addr_d    = addr_q;
    ra_d      = ra_q;
    rd_vld_d  = 1'b0;
    rd_idx_d  = rd_idx_q;
    cnt_d     = cnt_q;
    start_d   = start_q;
    prev_d    = prev_q;
    first_d   = first_q;
    wr_idx_d  = wr_idx_q;
    wr_val_d  = wr_val_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;
    map_req_o = '0;

    unique case (state_q)
      cpfa_pkg::S_CLEAR: begin
        map_req_o.we    = 1'b1;
        map_req_o.waddr = wr_idx_q;
        map_req_o.wdata = '0;
        wr_idx_d        = wr_idx_q + 1'b1;
      end
      cpfa_pkg::S_IDLE: begin
        if (start_i) begin
          op_d   = req_i.operation;
          len_d  = req_i.run_length;
          addr_d = req_i.free_address;
        end
      end
      cpfa_pkg::S_DECODE: begin
        unique case (op_q)
          cpfa_pkg::OP_ALLOC: begin
            if (alloc_bad) begin
              done_d = 1'b1;
              rsp_d  = '{status: cpfa_pkg::ST_BAD, run_address: '0};
            end else begin
              ra_d  = '0;
              cnt_d = '0;
            end
          end
          cpfa_pkg::OP_FREE: begin
            if (free_bad) begin
              done_d = 1'b1;
              rsp_d  = '{status: cpfa_pkg::ST_BAD, run_address: '0};
            end else begin
              map_req_o.re    = 1'b1;
              map_req_o.raddr = page_idx[cpfa_pkg::IDX_W-1:0];
              rd_idx_d        = page_idx[cpfa_pkg::IDX_W-1:0];
              rd_vld_d        = 1'b1;
              first_d         = 1'b1;
            end
          end
          default: ;
        endcase
      end
      cpfa_pkg::S_SCAN: begin
        // stream reads in order
        if (scan_issue) begin
          map_req_o.re    = 1'b1;
          map_req_o.raddr = ra_q[cpfa_pkg::IDX_W-1:0];
          rd_idx_d        = ra_q[cpfa_pkg::IDX_W-1:0];
          rd_vld_d        = 1'b1;
          ra_d            = ra_q + 1'b1;
        end
        // count free entries in a row
        if (rd_vld_q) begin
          if (scan_free) begin
            if (cnt_q == '0) start_d = rd_idx_q;
            cnt_d = cnt_q + 1'b1;
          end else begin
            cnt_d = '0;
          end
          priority if (scan_hit) begin
            wr_idx_d = (cnt_q == '0) ? rd_idx_q : start_q;
            wr_val_d = cpfa_pkg::ENTRY_W'(1);
          end else if (scan_last) begin
            done_d = 1'b1;
            rsp_d  = '{status: cpfa_pkg::ST_NOROOM, run_address: '0};
          end else begin
            // run not long enough yet, keep scanning
          end
        end
      end
      cpfa_pkg::S_WRITE: begin
        map_req_o.we    = 1'b1;
        map_req_o.waddr = wr_idx_q;
        map_req_o.wdata = wr_val_q;
        wr_idx_d        = wr_idx_q + 1'b1;
        wr_val_d        = wr_val_q + 1'b1;
        if (write_last) begin
          done_d = 1'b1;
          rsp_d  = '{status: cpfa_pkg::ST_DONE,
                     run_address: frame_base_i + (32'(start_q) << cpfa_pkg::PAGE_SHIFT)};
        end
      end
      cpfa_pkg::S_FREE: begin
        if (free_cont) begin
          map_req_o.we    = 1'b1;
          map_req_o.waddr = rd_idx_q;
          map_req_o.wdata = '0;
          prev_d          = map_rdata_i;
          first_d         = 1'b0;
          if (free_more) begin
            map_req_o.re    = 1'b1;
            map_req_o.raddr = next_k[cpfa_pkg::IDX_W-1:0];
            rd_idx_d        = next_k[cpfa_pkg::IDX_W-1:0];
            rd_vld_d        = 1'b1;
          end else begin
            done_d = 1'b1;
            rsp_d  = '{status: cpfa_pkg::ST_DONE, run_address: '0};
          end
        end else begin
          // an already free first page is refused; otherwise the run has ended
          done_d = 1'b1;
          rsp_d  = '{status: (first_q ? cpfa_pkg::ST_BAD : cpfa_pkg::ST_DONE),
                     run_address: '0};
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= cpfa_pkg::S_CLEAR;
      wr_idx_q <= '0;
      rd_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      wr_idx_q <= wr_idx_d;
      rd_vld_q <= rd_vld_d;
      done_q   <= done_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    len_q    <= len_d;
    addr_q   <= addr_d;
    ra_q     <= ra_d;
    rd_idx_q <= rd_idx_d;
    cnt_q    <= cnt_d;
    start_q  <= start_d;
    prev_q   <= prev_d;
    first_q  <= first_d;
    wr_val_q <= wr_val_d;
    rsp_q    <= rsp_d;
  end

  assign busy_o   = (state_q != cpfa_pkg::S_IDLE);
  assign done_o   = done_q;
  assign result_o = rsp_q;

  `CPFA_ASSERT_IMPL(a_done_when_idle, done_o, !busy_o, "result strobe while busy")
  `CPFA_ASSERT_NEXT(a_single_result, done_o, !done_o, "two result strobes in a row")
  `CPFA_ASSERT_IMPL(a_no_rw_collision, map_req_o.we && map_req_o.re, map_req_o.waddr != map_req_o.raddr, "map read and write hit the same entry")
  `CPFA_ASSERT_IMPL(a_fail_no_addr, done_o && (result_o.status != cpfa_pkg::ST_DONE), result_o.run_address == '0, "failed item carries an address")

endmodule

`default_nettype wire
